// File: design/vga_pkg.sv
// Shared types and constants for the voxel grid accumulator.
// No dependencies; used by the front end, back end and top level.
package vga_pkg;

   // default grid dimensions
   localparam int GRID_X_DEF = 32;
   localparam int GRID_Y_DEF = 32;
   localparam int GRID_Z_DEF = 32;

   // payload widths
   localparam int CMD_W   = 2;
   localparam int COORD_W = 32;
   localparam int SIZE_W  = 24;
   localparam int EV_W    = 16;
   localparam int INT_W   = 16;
   localparam int IDX_W   = 8;
   localparam int SUM_W   = 32;
   localparam int CNT_W   = 16;
   localparam int CSR_IW  = 3;

   // command codes
   localparam logic [CMD_W-1:0] CMD_ACC   = 2'd0;
   localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

   // register indexes
   localparam logic [CSR_IW-1:0] REG_ORIGIN_X = 3'd0;
   localparam logic [CSR_IW-1:0] REG_ORIGIN_Y = 3'd1;
   localparam logic [CSR_IW-1:0] REG_ORIGIN_Z = 3'd2;
   localparam logic [CSR_IW-1:0] REG_SIZE_X   = 3'd3;
   localparam logic [CSR_IW-1:0] REG_SIZE_Y   = 3'd4;
   localparam logic [CSR_IW-1:0] REG_SIZE_Z   = 3'd5;

   localparam logic [SIZE_W-1:0] SIZE_RST = 24'd256;

   // operation handed from front to back
   typedef enum logic [1:0] {
      OP_NONE,
      OP_ACC,
      OP_READ,
      OP_CLEAR
   } op_type;

   localparam int OP_W = 2;

   // back-end status seen by the front
   typedef struct packed {
      logic init_busy;
      logic q_full;
   } front_stat_type;

endpackage

// File: design/vga_front.sv
// Front end: holds configuration, accepts commands, maps points to voxel addresses
// with an iterative divider. Depends on vga_pkg.
module vga_front #(
   parameter int GRID_X = vga_pkg::GRID_X_DEF,
   parameter int GRID_Y = vga_pkg::GRID_Y_DEF,
   parameter int GRID_Z = vga_pkg::GRID_Z_DEF,
   parameter int AW     = 15
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic [vga_pkg::CMD_W-1:0]       req_cmd,
   input  logic signed [vga_pkg::COORD_W-1:0] req_point_x,
   input  logic signed [vga_pkg::COORD_W-1:0] req_point_y,
   input  logic signed [vga_pkg::COORD_W-1:0] req_point_z,
   input  logic signed [vga_pkg::EV_W-1:0] req_add_evidence,
   input  logic [vga_pkg::INT_W-1:0]       req_add_intensity,
   input  logic [vga_pkg::IDX_W-1:0]       req_read_x,
   input  logic [vga_pkg::IDX_W-1:0]       req_read_y,
   input  logic [vga_pkg::IDX_W-1:0]       req_read_z,
   input  logic                            csr_valid,
   input  logic [vga_pkg::CSR_IW-1:0]      csr_index,
   input  logic [vga_pkg::COORD_W-1:0]     csr_data,
   input  vga_pkg::front_stat_type         stat,
   output logic                            push,
   output logic [vga_pkg::OP_W+vga_pkg::EV_W+vga_pkg::INT_W+AW-1:0] push_data
);

   typedef enum logic [1:0] {F_IDLE, F_CAP, F_DIV, F_LIN} fstate_type;

   fstate_type state_ff;
   logic [vga_pkg::CMD_W-1:0]   cmd_ff;
   logic [vga_pkg::COORD_W-1:0] pt_ff   [3];
   logic [vga_pkg::COORD_W-1:0] org_ff  [3];
   logic [vga_pkg::SIZE_W-1:0]  size_ff [3];
   logic [vga_pkg::IDX_W-1:0]   ridx_ff [3];
   logic [32:0]                 rem_ff  [3];
   logic [32:0]                 rem_in  [3];
   logic [7:0]                  q_ff    [3];
   logic                        ge      [3];
   logic [2:0]                  inb_ff;
   logic [2:0]                  bit_ff;
   logic [vga_pkg::EV_W-1:0]    ev_ff;
   logic [vga_pkg::INT_W-1:0]   int_ff;
   logic [32:0]                 diff    [3];
   logic [32:0]                 mag     [3];
   logic [32:0]                 lim     [3];
   logic [2:0]                  inb_in;
   logic [7:0]                  ix, iy, iz;
   logic [AW-1:0]               lin;
   vga_pkg::op_type             op;
   logic                        rd_ok;

   function automatic logic [8:0] dim_of(input int a);
      dim_of = (a == 0) ? 9'(GRID_X) : ((a == 1) ? 9'(GRID_Y) : 9'(GRID_Z));
   endfunction

   assign busy = (state_ff != F_IDLE) || stat.init_busy;

   // axis offset, magnitude and bounds (negative side truncates to zero)
   always_comb begin
      for (int a = 0; a < 3; a++) begin
         diff[a] = {pt_ff[a][31], pt_ff[a]} - {org_ff[a][31], org_ff[a]};
         mag[a]  = diff[a][32] ? (~diff[a] + 33'd1) : diff[a];
         lim[a]  = 33'(dim_of(a)) * {9'd0, size_ff[a]};
         inb_in[a] = diff[a][32] ? (mag[a] < {9'd0, size_ff[a]}) : (mag[a] < lim[a]);
      end
   end

   // one quotient bit per axis each cycle
   always_comb begin
      for (int a = 0; a < 3; a++) begin
         ge[a]     = rem_ff[a] >= (33'(size_ff[a]) << bit_ff);
         rem_in[a] = ge[a] ? (rem_ff[a] - (33'(size_ff[a]) << bit_ff)) : rem_ff[a];
      end
   end

   // index selection, op classification and linear address
   always_comb begin
      rd_ok = (32'(ridx_ff[0]) < 32'(GRID_X)) && (32'(ridx_ff[1]) < 32'(GRID_Y)) &&
              (32'(ridx_ff[2]) < 32'(GRID_Z));
      if (cmd_ff == vga_pkg::CMD_ACC) begin
         ix = q_ff[0];
         iy = q_ff[1];
         iz = q_ff[2];
         op = (&inb_ff) ? vga_pkg::OP_ACC : vga_pkg::OP_NONE;
      end else begin
         ix = ridx_ff[0];
         iy = ridx_ff[1];
         iz = ridx_ff[2];
         if (cmd_ff == vga_pkg::CMD_READ)
            op = rd_ok ? vga_pkg::OP_READ : vga_pkg::OP_NONE;
         else if (cmd_ff == vga_pkg::CMD_CLEAR)
            op = vga_pkg::OP_CLEAR;
         else
            op = vga_pkg::OP_NONE;
      end
      lin = AW'(ix) + AW'(iy) * AW'(GRID_X) + AW'(iz) * AW'(GRID_X * GRID_Y);
   end

   assign push      = (state_ff == F_LIN) && !stat.q_full;
   assign push_data = {op, ev_ff, int_ff, lin};

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int a = 0; a < 3; a++) begin
            org_ff[a]  <= '0;
            size_ff[a] <= vga_pkg::SIZE_RST;
         end
      end else if (csr_valid) begin
         unique case (csr_index)
            vga_pkg::REG_ORIGIN_X: org_ff[0]  <= csr_data;
            vga_pkg::REG_ORIGIN_Y: org_ff[1]  <= csr_data;
            vga_pkg::REG_ORIGIN_Z: org_ff[2]  <= csr_data;
            vga_pkg::REG_SIZE_X:   size_ff[0] <= csr_data[vga_pkg::SIZE_W-1:0];
            vga_pkg::REG_SIZE_Y:   size_ff[1] <= csr_data[vga_pkg::SIZE_W-1:0];
            vga_pkg::REG_SIZE_Z:   size_ff[2] <= csr_data[vga_pkg::SIZE_W-1:0];
            default: ;
         endcase
      end
   end

   // sequencer: capture, offset, divide, address
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
         bit_ff   <= '0;
      end else begin
         unique case (state_ff)
            F_IDLE: begin
               if (start && !busy) begin
                  cmd_ff     <= req_cmd;
                  pt_ff[0]   <= req_point_x;
                  pt_ff[1]   <= req_point_y;
                  pt_ff[2]   <= req_point_z;
                  ev_ff      <= req_add_evidence;
                  int_ff     <= req_add_intensity;
                  ridx_ff[0] <= req_read_x;
                  ridx_ff[1] <= req_read_y;
                  ridx_ff[2] <= req_read_z;
                  state_ff   <= F_CAP;
               end
            end
            F_CAP: begin
               for (int a = 0; a < 3; a++) begin
                  rem_ff[a] <= mag[a];
                  q_ff[a]   <= '0;
               end
               inb_ff   <= inb_in;
               bit_ff   <= 3'd7;
               state_ff <= (cmd_ff == vga_pkg::CMD_ACC) ? F_DIV : F_LIN;
            end
            F_DIV: begin
               for (int a = 0; a < 3; a++) begin
                  rem_ff[a] <= rem_in[a];
                  q_ff[a]   <= {q_ff[a][6:0], ge[a]};
               end
               bit_ff <= bit_ff - 3'd1;
               if (bit_ff == 3'd0)
                  state_ff <= F_LIN;
            end
            F_LIN: begin
               if (!stat.q_full)
                  state_ff <= F_IDLE;
            end
            default: state_ff <= F_IDLE;
         endcase
      end
   end

endmodule

// File: design/vga_queue.sv
// Two-entry queue between the front and back ends.
// No dependencies.
module vga_queue #(
   parameter int W = 8
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  logic [W-1:0] push_data,
   input  logic         pop,
   output logic [W-1:0] head,
   output logic         empty,
   output logic         full
);

   logic [W-1:0] slot_ff [2];
   logic         wr_ff, rd_ff;
   logic [1:0]   cnt_ff;

   assign empty = (cnt_ff == 2'd0);
   assign full  = (cnt_ff == 2'd2);
   assign head  = slot_ff[rd_ff];

   // payload slots
   always_ff @(posedge clock) begin
      if (push)
         slot_ff[wr_ff] <= push_data;
   end

   // pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= '0;
      end else begin
         if (push) wr_ff <= ~wr_ff;
         if (pop)  rd_ff <= ~rd_ff;
         cnt_ff <= cnt_ff + {1'b0, push} - {1'b0, pop};
      end
   end

endmodule

// File: design/vga_back.sv
// Back end: voxel store with read-modify-write, reads, clear sweep and result port.
// Depends on vga_pkg.
module vga_back #(
   parameter int VOX = 32768,
   parameter int AW  = 15
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [vga_pkg::OP_W+vga_pkg::EV_W+vga_pkg::INT_W+AW-1:0] head,
   input  logic                              empty,
   output logic                              pop,
   output logic                              init_busy,
   output logic                              rsp_valid,
   output logic                              rsp_ok,
   output logic signed [vga_pkg::SUM_W-1:0]  rsp_evidence_sum,
   output logic [vga_pkg::SUM_W-1:0]         rsp_intensity_sum,
   output logic [vga_pkg::CNT_W-1:0]         rsp_obs_count
);

   localparam int QW = vga_pkg::OP_W + vga_pkg::EV_W + vga_pkg::INT_W + AW;

   typedef enum logic [2:0] {B_INIT, B_IDLE, B_RD, B_EXE, B_CLR} bstate_type;

   bstate_type state_ff;
   logic [AW-1:0]               clr_ff;
   logic [AW-1:0]               addr_ff;
   vga_pkg::op_type             op_ff;
   vga_pkg::op_type             head_op;
   logic [vga_pkg::EV_W-1:0]    ev_ff;
   logic [vga_pkg::INT_W-1:0]   int_ff;
   logic [vga_pkg::SUM_W-1:0]   ev_mem  [VOX];
   logic [vga_pkg::SUM_W-1:0]   int_mem [VOX];
   logic [vga_pkg::CNT_W-1:0]   cnt_mem [VOX];
   logic [vga_pkg::SUM_W-1:0]   ev_rd_ff, int_rd_ff;
   logic [vga_pkg::CNT_W-1:0]   cnt_rd_ff;
   logic                        sweep, we;
   logic [AW-1:0]               waddr;
   logic [vga_pkg::SUM_W-1:0]   ev_wr, int_wr;
   logic [vga_pkg::CNT_W-1:0]   cnt_wr;
   logic [32:0]                 ev_sum, int_sum;
   logic                        rsp_valid_ff, rsp_ok_ff;
   logic [vga_pkg::SUM_W-1:0]   rsp_ev_ff, rsp_int_ff;
   logic [vga_pkg::CNT_W-1:0]   rsp_cnt_ff;

   assign init_busy = (state_ff == B_INIT);
   assign pop       = (state_ff == B_IDLE) && !empty;
   assign sweep     = (state_ff == B_INIT) || (state_ff == B_CLR);
   assign head_op   = vga_pkg::op_type'(head[QW-1 -: vga_pkg::OP_W]);

   // saturating update of the fetched voxel
   always_comb begin
      ev_sum  = {ev_rd_ff[31], ev_rd_ff} + {{17{ev_ff[15]}}, ev_ff};
      int_sum = {1'b0, int_rd_ff} + {17'd0, int_ff};
      if (sweep) begin
         ev_wr  = '0;
         int_wr = '0;
         cnt_wr = '0;
      end else begin
         if (ev_sum[32] != ev_sum[31])
            ev_wr = ev_sum[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
         else
            ev_wr = ev_sum[31:0];
         int_wr = int_sum[32] ? 32'hFFFF_FFFF : int_sum[31:0];
         cnt_wr = (&cnt_rd_ff) ? cnt_rd_ff : cnt_rd_ff + 16'd1;
      end
      we    = sweep || ((state_ff == B_EXE) && (op_ff == vga_pkg::OP_ACC));
      waddr = sweep ? clr_ff : addr_ff;
   end

   // voxel store, registered read at the current address
   always_ff @(posedge clock) begin
      if (we) begin
         ev_mem[waddr]  <= ev_wr;
         int_mem[waddr] <= int_wr;
         cnt_mem[waddr] <= cnt_wr;
      end
      ev_rd_ff  <= ev_mem[addr_ff];
      int_rd_ff <= int_mem[addr_ff];
      cnt_rd_ff <= cnt_mem[addr_ff];
   end

   // sequencer and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_INIT;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            B_INIT, B_CLR: begin
               if (clr_ff == AW'(VOX - 1)) begin
                  clr_ff   <= '0;
                  state_ff <= B_IDLE;
                  if (state_ff == B_CLR) begin
                     rsp_valid_ff <= 1'b1;
                     rsp_ok_ff    <= 1'b1;
                     rsp_ev_ff    <= '0;
                     rsp_int_ff   <= '0;
                     rsp_cnt_ff   <= '0;
                  end
               end else begin
                  clr_ff <= clr_ff + AW'(1);
               end
            end
            B_IDLE: begin
               if (!empty) begin
                  op_ff    <= head_op;
                  ev_ff    <= head[QW-vga_pkg::OP_W-1 -: vga_pkg::EV_W];
                  int_ff   <= head[vga_pkg::INT_W+AW-1 -: vga_pkg::INT_W];
                  addr_ff  <= head[AW-1:0];
                  state_ff <= (head_op == vga_pkg::OP_CLEAR) ? B_CLR : B_RD;
               end
            end
            B_RD: state_ff <= B_EXE;
            B_EXE: begin
               rsp_valid_ff <= 1'b1;
               rsp_ok_ff    <= (op_ff != vga_pkg::OP_NONE);
               rsp_ev_ff    <= (op_ff == vga_pkg::OP_READ) ? ev_rd_ff  : '0;
               rsp_int_ff   <= (op_ff == vga_pkg::OP_READ) ? int_rd_ff : '0;
               rsp_cnt_ff   <= (op_ff == vga_pkg::OP_READ) ? cnt_rd_ff : '0;
               state_ff     <= B_IDLE;
            end
            default: state_ff <= B_IDLE;
         endcase
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_ok            = rsp_ok_ff;
   assign rsp_evidence_sum  = rsp_ev_ff;
   assign rsp_intensity_sum = rsp_int_ff;
   assign rsp_obs_count     = rsp_cnt_ff;

   // results never come back to back
   a_rsp_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |=> !rsp_valid_ff) else $error("back-to-back results");
   // no result while the reset sweep runs
   a_init_quiet: assert property (@(posedge clock) disable iff (reset)
      (state_ff == B_INIT) |-> !rsp_valid_ff) else $error("result during init sweep");
   // an item leaves the queue only when one is there
   a_pop_ok: assert property (@(posedge clock) disable iff (reset)
      pop |-> !empty) else $error("pop from empty queue");
   // the store is written only by a sweep or an accumulate
   a_we_src: assert property (@(posedge clock) disable iff (reset)
      we |-> (sweep || op_ff == vga_pkg::OP_ACC)) else $error("stray store write");

endmodule

// File: design/voxel_grid_accumulator_core.sv
// Top level of the voxel grid accumulator: front end, queue, back end.
// Depends on vga_pkg, vga_front, vga_queue, vga_back.
//
//  channel | ports                         | handshake
//  --------+-------------------------------+----------------------------------
//  request | start, busy, req_*            | beat taken when start && !busy
//  result  | rsp_valid, rsp_*              | one-cycle strobe, never stalled
//  config  | csr_valid, csr_ready, csr_*   | beat when csr_valid && csr_ready
//
// Accumulate: the front captures, computes offset and bounds, runs the
// bit-serial divider (one quotient bit per axis a cycle) and hands off to the
// queue, waiting while it is full; the back pops, reads the store, does the
// modify-write and strobes the result. The front takes the next beat once it
// has handed off, while the back still works. Read and unused skip the divider.
// Clear sweeps every voxel, one a cycle; so does reset, holding busy high.
// The result side has no backpressure; the two-entry queue absorbs back delay.
module voxel_grid_accumulator_core #(
   parameter int GRID_X = vga_pkg::GRID_X_DEF,
   parameter int GRID_Y = vga_pkg::GRID_Y_DEF,
   parameter int GRID_Z = vga_pkg::GRID_Z_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic [vga_pkg::CMD_W-1:0]          req_cmd,
   input  logic signed [vga_pkg::COORD_W-1:0] req_point_x,
   input  logic signed [vga_pkg::COORD_W-1:0] req_point_y,
   input  logic signed [vga_pkg::COORD_W-1:0] req_point_z,
   input  logic signed [vga_pkg::EV_W-1:0]    req_add_evidence,
   input  logic [vga_pkg::INT_W-1:0]          req_add_intensity,
   input  logic [vga_pkg::IDX_W-1:0]          req_read_x,
   input  logic [vga_pkg::IDX_W-1:0]          req_read_y,
   input  logic [vga_pkg::IDX_W-1:0]          req_read_z,
   output logic                               rsp_valid,
   output logic                               rsp_ok,
   output logic signed [vga_pkg::SUM_W-1:0]   rsp_evidence_sum,
   output logic [vga_pkg::SUM_W-1:0]          rsp_intensity_sum,
   output logic [vga_pkg::CNT_W-1:0]          rsp_obs_count,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [vga_pkg::CSR_IW-1:0]         csr_index,
   input  logic [vga_pkg::COORD_W-1:0]        csr_data
);

   localparam int VOX = GRID_X * GRID_Y * GRID_Z;
   localparam int AW  = (VOX > 1) ? $clog2(VOX) : 1;
   localparam int QW  = vga_pkg::OP_W + vga_pkg::EV_W + vga_pkg::INT_W + AW;

   vga_pkg::front_stat_type stat;
   logic          push, pop, q_empty, q_full, init_busy;
   logic [QW-1:0] push_data, head;

   assign csr_ready      = 1'b1;
   assign stat.init_busy = init_busy;
   assign stat.q_full    = q_full;

   vga_front #(.GRID_X(GRID_X), .GRID_Y(GRID_Y), .GRID_Z(GRID_Z), .AW(AW)) u_front (
      .clock, .reset, .start, .busy,
      .req_cmd, .req_point_x, .req_point_y, .req_point_z,
      .req_add_evidence, .req_add_intensity,
      .req_read_x, .req_read_y, .req_read_z,
      .csr_valid, .csr_index, .csr_data,
      .stat, .push, .push_data
   );

   vga_queue #(.W(QW)) u_queue (
      .clock, .reset, .push, .push_data, .pop, .head,
      .empty(q_empty), .full(q_full)
   );

   vga_back #(.VOX(VOX), .AW(AW)) u_back (
      .clock, .reset, .head, .empty(q_empty), .pop, .init_busy,
      .rsp_valid, .rsp_ok, .rsp_evidence_sum, .rsp_intensity_sum, .rsp_obs_count
   );

endmodule
